>>> hw/rtl/rl_pkg.sv
// Shared types, constants and codes for the per-client auth rate limiter.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`default_nettype none

package rl_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PAD_ENTRIES = 1 << IDX_W;

  // operation codes
  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_FAIL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_FAILURES = 2'd0;
  localparam logic [1:0] REG_WINDOW_LEN   = 2'd1;
  localparam logic [1:0] REG_BLOCK_LEN    = 2'd2;

  localparam logic [7:0]  MAX_FAILURES_RST = 8'd5;
  localparam logic [31:0] WINDOW_LEN_RST   = 32'd60000;
  localparam logic [30:0] BLOCK_LEN_RST    = 31'd120000;
  localparam logic [7:0]  COUNT_CEILING    = 8'd255;

  // ceil(rem / 1000) = ((rem + 999) * RECIP_1000) >> RECIP_SHIFT, exact below 2^32
  localparam logic [31:0] ROUND_UP_MS = 32'd999;
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [31:0]      word_t;

  typedef struct packed {
    idx_t sel;
    logic fresh;
  } look_t;

  typedef struct packed {
    logic        limited;
    logic [30:0] rem_ms;
    logic [2:0]  slot;
    logic        allocated;
    logic [7:0]  failures;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rl_lookup.sv
// Entry selection: key match, first empty entry, else oldest window (tree).
// Depends on rl_pkg.
`default_nettype none

module rl_lookup (
  input  wire logic           entry_valid [rl_pkg::TABLE_ENTRIES],
  input  wire rl_pkg::word_t  entry_key [rl_pkg::TABLE_ENTRIES],
  input  wire rl_pkg::word_t  entry_window_start [rl_pkg::TABLE_ENTRIES],
  input  wire rl_pkg::word_t  key,
  input  wire rl_pkg::word_t  now,
  output rl_pkg::look_t       look
);

  logic         hit;
  rl_pkg::idx_t hit_idx;
  logic         has_empty;
  rl_pkg::idx_t empty_idx;
  rl_pkg::word_t age  [rl_pkg::IDX_W+1][rl_pkg::PAD_ENTRIES];
  rl_pkg::idx_t  widx [rl_pkg::IDX_W+1][rl_pkg::PAD_ENTRIES];

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    has_empty = 1'b0;
    empty_idx = '0;
    for (int i = 0; i < rl_pkg::TABLE_ENTRIES; i++) begin
      if (!hit && entry_valid[i] && entry_key[i] == key) begin
        hit     = 1'b1;
        hit_idx = rl_pkg::IDX_W'(i);
      end
      if (!has_empty && !entry_valid[i]) begin
        has_empty = 1'b1;
        empty_idx = rl_pkg::IDX_W'(i);
      end
    end
  end

  // oldest window: right side wins only when strictly older, so ties go low
  always_comb begin
    age  = '{default: '0};
    widx = '{default: '0};
    for (int i = 0; i < rl_pkg::PAD_ENTRIES; i++) begin
      widx[0][i] = rl_pkg::IDX_W'(i);
    end
    for (int i = 0; i < rl_pkg::TABLE_ENTRIES; i++) begin
      age[0][i] = now - entry_window_start[i];
    end
    for (int l = 0; l < rl_pkg::IDX_W; l++) begin
      for (int j = 0; j < (rl_pkg::PAD_ENTRIES >> (l + 1)); j++) begin
        if (age[l][2*j+1] > age[l][2*j]) begin
          age[l+1][j]  = age[l][2*j+1];
          widx[l+1][j] = widx[l][2*j+1];
        end else begin
          age[l+1][j]  = age[l][2*j];
          widx[l+1][j] = widx[l][2*j];
        end
      end
    end
  end

  always_comb begin
    look.fresh = !hit;
    if (hit) begin
      look.sel = hit_idx;
    end else if (has_empty) begin
      look.sel = empty_idx;
    end else begin
      look.sel = widx[rl_pkg::IDX_W][0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rl_retry.sv
// Output stage: turns the remaining block time into whole seconds, rounded up,
// and holds the result beat for the consumer. Depends on rl_pkg.
`default_nettype none

module rl_retry (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rl_pkg::res_t res,
  input  wire logic        res_valid,
  output logic             take,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic             limited,
  output logic [21:0]      retry_secs,
  output logic [2:0]       slot,
  output logic             allocated,
  output logic [7:0]       failures_now
);

  logic [31:0] rounded;
  logic [60:0] product;

  assign take    = !rsp_valid || !rsp_stall;
  assign rounded = {1'b0, res.rem_ms} + rl_pkg::ROUND_UP_MS;
  assign product = 61'(rounded) * 61'(rl_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      limited      <= res.limited;
      retry_secs   <= product[rl_pkg::RECIP_SHIFT +: 22];
      slot         <= res.slot;
      allocated    <= res.allocated;
      failures_now <= res.failures;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/per_client_auth_rate_limiter.sv
// Top level of the per-client auth rate limiter: input register, entry table,
// per-event update and configuration. Depends on rl_pkg, rl_lookup, rl_retry.
//
//  channel | direction | handshake             | beat
//  req     | in        | req_valid / req_stall | operation, client_addr, addr_valid, now_ms
//  rsp     | out       | rsp_valid / rsp_stall | limited, retry_secs, slot, allocated,
//          |           |                       | failures_now
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One event per cycle sustained while rsp is not stalled. A beat goes from the input
// register to the result register (lookup, table update), then to rsp (seconds multiply).
// The table is read and written in the same cycle, so back-to-back events on one
// client see each other's updates. Synchronous reset empties the table and loads
// the default limits. A stalled rsp holds its beat and backs up into req_stall.
`default_nettype none

module per_client_auth_rate_limiter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] client_addr,
  input  wire logic        addr_valid,
  input  wire logic [31:0] now_ms,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic             limited,
  output logic [21:0]      retry_secs,
  output logic [2:0]       slot,
  output logic             allocated,
  output logic [7:0]       failures_now,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration
  logic [7:0]  max_failures;
  logic [31:0] window_length_ms;
  logic [30:0] block_length_ms;

  // input register
  logic          in_v;
  logic [1:0]    in_op;
  rl_pkg::word_t in_key;
  logic          in_present;
  rl_pkg::word_t in_now;

  // table
  logic          entry_valid        [rl_pkg::TABLE_ENTRIES];
  rl_pkg::word_t entry_key          [rl_pkg::TABLE_ENTRIES];
  logic [7:0]    entry_failures     [rl_pkg::TABLE_ENTRIES];
  rl_pkg::word_t entry_window_start [rl_pkg::TABLE_ENTRIES];
  rl_pkg::word_t entry_block_until  [rl_pkg::TABLE_ENTRIES];

  // result register
  logic         res_v;
  rl_pkg::res_t res;

  logic          take;
  logic          res_free;
  logic          work;
  logic          act;
  rl_pkg::look_t look;
  logic [7:0]    fail_next;
  rl_pkg::word_t ws_next;
  rl_pkg::word_t bu_next;
  rl_pkg::res_t  res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_failures     <= rl_pkg::MAX_FAILURES_RST;
      window_length_ms <= rl_pkg::WINDOW_LEN_RST;
      block_length_ms  <= rl_pkg::BLOCK_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rl_pkg::REG_MAX_FAILURES: max_failures     <= cfg_data[7:0];
        rl_pkg::REG_WINDOW_LEN:   window_length_ms <= cfg_data;
        rl_pkg::REG_BLOCK_LEN:    block_length_ms  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign res_free  = !res_v || take;
  assign work      = in_v && res_free;
  assign req_stall = in_v && !res_free;
  assign act       = in_present && (in_op != rl_pkg::OP_RSVD);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!req_stall) begin
      in_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_op      <= operation;
      in_key     <= client_addr;
      in_present <= addr_valid;
      in_now     <= now_ms;
    end
  end

  rl_lookup u_lookup (
    .entry_valid        (entry_valid),
    .entry_key          (entry_key),
    .entry_window_start (entry_window_start),
    .key                (in_key),
    .now                (in_now),
    .look               (look)
  );

  always_comb begin
    logic [7:0]    cur_fail;
    rl_pkg::word_t cur_bu;
    rl_pkg::word_t ahead_d;
    logic          blocked;
    logic [rl_pkg::IDX_W+2:0] sel_wide;

    // a fresh entry starts cleared with its window opening now
    cur_fail = look.fresh ? 8'd0 : entry_failures[look.sel];
    ws_next  = look.fresh ? in_now : entry_window_start[look.sel];
    cur_bu   = look.fresh ? 32'd0 : entry_block_until[look.sel];
    ahead_d  = cur_bu - in_now;
    blocked  = (cur_bu != 32'd0) && (ahead_d != 32'd0) && !ahead_d[31];
    sel_wide = {3'b000, look.sel};

    fail_next = cur_fail;
    bu_next   = cur_bu;
    res_next  = '0;

    case (in_op)
      rl_pkg::OP_CHECK: begin
        if (blocked) begin
          res_next.limited = 1'b1;
          res_next.rem_ms  = ahead_d[30:0];
        end else if (cur_bu != 32'd0) begin
          bu_next   = '0;
          fail_next = '0;
          ws_next   = in_now;
        end
      end
      rl_pkg::OP_FAIL: begin
        if (!blocked) begin
          if ((in_now - ws_next) > window_length_ms) begin
            ws_next   = in_now;
            fail_next = '0;
          end
          if (fail_next != rl_pkg::COUNT_CEILING) begin
            fail_next = fail_next + 8'd1;
          end
          if (fail_next >= max_failures) begin
            bu_next = in_now + {1'b0, block_length_ms};
          end
        end
      end
      rl_pkg::OP_CLEAR: begin
        fail_next = '0;
        ws_next   = in_now;
        bu_next   = '0;
      end
      default: ;
    endcase

    if (act) begin
      res_next.slot      = sel_wide[2:0];
      res_next.allocated = look.fresh;
      res_next.failures  = fail_next;
    end else begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rl_pkg::TABLE_ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (work && act) begin
      entry_valid[look.sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (work && act) begin
      entry_key[look.sel]          <= in_key;
      entry_failures[look.sel]     <= fail_next;
      entry_window_start[look.sel] <= ws_next;
      entry_block_until[look.sel]  <= bu_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (res_free) begin
      res_v <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      res <= res_next;
    end
  end

  rl_retry u_retry (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .res_valid    (res_v),
    .take         (take),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .limited      (limited),
    .retry_secs   (retry_secs),
    .slot         (slot),
    .allocated    (allocated),
    .failures_now (failures_now)
  );

endmodule

`default_nettype wire

>>> tb/per_client_auth_rate_limiter_tb.sv
// Self-checking bench for per_client_auth_rate_limiter: a lockout scoreboard predicts each
// response beat from the accepted request beats and the current limits; plain tasks drive
// requests and register writes. Depends on rl_pkg and the RTL only.
`timescale 1ns / 1ps

module per_client_auth_rate_limiter_tb;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic        limited;
    logic [21:0] retry;
    logic [2:0]  slot;
    logic        allocated;
    logic [7:0]  failures;
  } verdict_t;

  class lockout_scoreboard;
    bit [7:0]    fail_limit;
    bit [31:0]   window_ms;
    bit [30:0]   block_ms;
    bit          used [rl_pkg::TABLE_ENTRIES];
    bit [31:0]   owner [rl_pkg::TABLE_ENTRIES];
    bit [7:0]    count [rl_pkg::TABLE_ENTRIES];
    bit [31:0]   win_start [rl_pkg::TABLE_ENTRIES];
    bit [31:0]   block_end [rl_pkg::TABLE_ENTRIES];
    verdict_t    pending_verdicts[$];
    int unsigned resolved;
    int unsigned mismatches;

    function new();
      fail_limit = rl_pkg::MAX_FAILURES_RST;
      window_ms  = rl_pkg::WINDOW_LEN_RST;
      block_ms   = rl_pkg::BLOCK_LEN_RST;
      foreach (used[i]) used[i] = 1'b0;
      resolved   = 0;
      mismatches = 0;
    endfunction

    function void set_limit_reg(input logic [1:0] idx, input logic [31:0] data);
      case (idx)
        rl_pkg::REG_MAX_FAILURES: fail_limit = data[7:0];
        rl_pkg::REG_WINDOW_LEN:   window_ms  = data;
        rl_pkg::REG_BLOCK_LEN:    block_ms   = data[30:0];
        default: ;
      endcase
    endfunction

    // matching entry, else first empty one, else the one whose window began longest ago
    function int unsigned claim_entry(input logic [31:0] addr, input logic [31:0] at_ms,
                                      output bit fresh);
      int unsigned hole;
      int unsigned oldest;
      hole   = rl_pkg::TABLE_ENTRIES;
      oldest = 0;
      fresh  = 1'b0;
      for (int unsigned i = 0; i < rl_pkg::TABLE_ENTRIES; i++) begin
        if (!used[i]) begin
          if (hole == rl_pkg::TABLE_ENTRIES) hole = i;
        end else if (owner[i] == addr) begin
          return i;
        end else if (32'(at_ms - win_start[i]) > 32'(at_ms - win_start[oldest])) begin
          oldest = i;
        end
      end
      if (hole != rl_pkg::TABLE_ENTRIES) oldest = hole;
      used[oldest]      = 1'b1;
      owner[oldest]     = addr;
      count[oldest]     = 8'd0;
      win_start[oldest] = at_ms;
      block_end[oldest] = 32'd0;
      fresh             = 1'b1;
      return oldest;
    endfunction

    // zero end time means no block; otherwise signed distance to the end must be positive
    function bit held_off(input int unsigned s, input logic [31:0] at_ms);
      bit [31:0] left;
      left = block_end[s] - at_ms;
      return block_end[s] != 32'd0 && left != 32'd0 && !left[31];
    endfunction

    function void note_event(input logic [1:0] op, input logic [31:0] addr,
                             input logic present, input logic [31:0] at_ms);
      verdict_t    v;
      int unsigned s;
      bit          fresh;
      bit [31:0]   left;
      v = '0;
      if (present !== 1'b1 || op == rl_pkg::OP_RSVD) begin
        pending_verdicts.push_back(v);
        return;
      end
      s = claim_entry(addr, at_ms, fresh);
      case (op)
        rl_pkg::OP_CHECK: begin
          if (held_off(s, at_ms)) begin
            left      = block_end[s] - at_ms;
            v.limited = 1'b1;
            v.retry   = 22'((64'(left) + 64'(MS_PER_S - 1)) / 64'(MS_PER_S));
          end else if (block_end[s] != 32'd0) begin
            block_end[s] = 32'd0;
            count[s]     = 8'd0;
            win_start[s] = at_ms;
          end
        end
        rl_pkg::OP_FAIL: begin
          if (!held_off(s, at_ms)) begin
            if (32'(at_ms - win_start[s]) > window_ms) begin
              win_start[s] = at_ms;
              count[s]     = 8'd0;
            end
            if (count[s] != rl_pkg::COUNT_CEILING) count[s] = count[s] + 8'd1;
            if (count[s] >= fail_limit) block_end[s] = at_ms + {1'b0, block_ms};
          end
        end
        default: begin
          count[s]     = 8'd0;
          win_start[s] = at_ms;
          block_end[s] = 32'd0;
        end
      endcase
      v.slot      = 3'(s);
      v.allocated = fresh;
      v.failures  = count[s];
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(input verdict_t got);
      verdict_t want;
      resolved++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response beat with nothing pending: lim=%0b retry=%0d slot=%0d",
                   $time, got.limited, got.retry, got.slot);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.limited !== want.limited || got.retry !== want.retry ||
          got.slot !== want.slot || got.allocated !== want.allocated ||
          got.failures !== want.failures) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: want lim=%0b retry=%0d slot=%0d alloc=%0b fails=%0d, got lim=%0b %s",
                   $time, want.limited, want.retry, want.slot, want.allocated, want.failures,
                   got.limited, $sformatf("retry=%0d slot=%0d alloc=%0b fails=%0d",
                   got.retry, got.slot, got.allocated, got.failures));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  operation = rl_pkg::OP_CHECK;
  logic [31:0] client_addr = 32'd0;
  logic        addr_valid = 1'b0;
  logic [31:0] now_ms = 32'd0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        limited;
  logic [21:0] retry_secs;
  logic [2:0]  slot;
  logic        allocated;
  logic [7:0]  failures_now;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = rl_pkg::REG_MAX_FAILURES;
  logic [31:0] cfg_data = 32'd0;

  lockout_scoreboard lockout_sb;
  int unsigned       events_sent = 0;
  bit                no_idle = 1'b0;

  per_client_auth_rate_limiter i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        lockout_sb.note_event(operation, client_addr, addr_valid, now_ms);
      if (rsp_valid && !rsp_stall)
        lockout_sb.check_verdict({limited, retry_secs, slot, allocated, failures_now});
    end
  end

  always @(posedge clk) begin
    rsp_stall <= !rst && !no_idle && ($urandom_range(0, 99) < 12);
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_event(input logic [1:0] op, input logic [31:0] addr,
                            input logic present, input logic [31:0] at_ms);
    logic ok;
    while (!no_idle && $urandom_range(0, 99) < 12) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    client_addr <= addr;
    addr_valid  <= present;
    now_ms      <= at_ms;
    do begin
      @(negedge clk);
      ok = !req_stall;
      @(posedge clk);
    end while (!ok);
    events_sent++;
  endtask

  task automatic post_reg(input logic [1:0] idx, input logic [31:0] data);
    logic ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    lockout_sb.set_limit_reg(idx, data);
  endtask

  // unused upper data bits are filled at random now and then
  task automatic configure(input logic [7:0] limit, input logic [31:0] window,
                           input logic [30:0] hold);
    post_reg(rl_pkg::REG_MAX_FAILURES,
             {($urandom_range(0, 1) != 0) ? 24'($urandom) : 24'd0, limit});
    post_reg(rl_pkg::REG_WINDOW_LEN, window);
    post_reg(rl_pkg::REG_BLOCK_LEN, {1'($urandom_range(0, 1)), hold});
    if ($urandom_range(0, 3) == 0) post_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (lockout_sb.resolved != events_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hammer: one client, failures and checks only, small steps, so the count can saturate
  task automatic run_phase(input logic [7:0] limit, input logic [31:0] window,
                           input logic [30:0] hold, input int unsigned unit,
                           input int unsigned nkeys, input bit hammer,
                           input int unsigned beats, input logic [31:0] start);
    logic [31:0] pool [12];
    logic [31:0] clock_ms;
    logic [31:0] addr;
    logic [1:0]  op;
    logic        present;
    int unsigned roll;
    settle();
    configure(limit, window, hold);
    pool[0] = 32'd0;
    pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 12; k++) pool[k] = $urandom;
    clock_ms = start;
    for (int unsigned n = 0; n < beats; n++) begin
      roll    = $urandom_range(0, 99);
      present = 1'b1;
      addr    = pool[$urandom_range(0, nkeys - 1)];
      if (hammer) begin
        op = (roll < 90) ? rl_pkg::OP_FAIL : rl_pkg::OP_CHECK;
      end else begin
        if (roll < 48) op = rl_pkg::OP_FAIL;
        else if (roll < 78) op = rl_pkg::OP_CHECK;
        else if (roll < 90) op = rl_pkg::OP_CLEAR;
        else if (roll < 94) op = rl_pkg::OP_RSVD;
        else begin
          op      = 2'($urandom_range(0, 3));
          present = 1'b0;
        end
        if ($urandom_range(0, 99) < 3) addr = $urandom;
      end
      roll = $urandom_range(0, 99);
      if (roll >= 8) begin
        if (roll < 88 || hammer) clock_ms = clock_ms + 32'($urandom_range(1, unit));
        else if (roll < 98) clock_ms = clock_ms + 32'($urandom_range(unit, unit * 10));
        else clock_ms = $urandom;
      end
      send_event(op, addr, present, clock_ms);
    end
  endtask

  initial begin
    lockout_sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default limits: ignored beats, count up to a block, expiry, clock wrap
    send_event(rl_pkg::OP_FAIL, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    send_event(rl_pkg::OP_RSVD, 32'd0, 1'b1, 32'd0);
    send_event(rl_pkg::OP_CHECK, 32'd0, 1'b1, 32'd0);
    for (int k = 1; k <= 5; k++) send_event(rl_pkg::OP_FAIL, 32'd0, 1'b1, 32'(k * 10));
    send_event(rl_pkg::OP_CHECK, 32'd0, 1'b1, 32'd60);
    send_event(rl_pkg::OP_FAIL, 32'd0, 1'b1, 32'd70);
    send_event(rl_pkg::OP_CHECK, 32'd0, 1'b1, 32'd200_000);
    send_event(rl_pkg::OP_CLEAR, 32'd0, 1'b1, 32'd200_010);
    send_event(rl_pkg::OP_FAIL, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF00);
    send_event(rl_pkg::OP_FAIL, 32'hFFFF_FFFF, 1'b1, 32'h0000_0100);

    // zero window, longest block: end time wrapping to zero, longest retry
    settle();
    configure(8'd1, 32'd0, 31'h7FFF_FFFF);
    send_event(rl_pkg::OP_FAIL, 32'h0A00_0001, 1'b1, 32'h8000_0001);
    send_event(rl_pkg::OP_CHECK, 32'h0A00_0001, 1'b1, 32'h8000_0001);
    send_event(rl_pkg::OP_FAIL, 32'h0A00_0002, 1'b1, 32'd5);
    send_event(rl_pkg::OP_CHECK, 32'h0A00_0002, 1'b1, 32'd5);

    // limit of zero blocks on the first failure
    settle();
    configure(8'd0, 32'd1000, 31'd40_000);
    send_event(rl_pkg::OP_FAIL, 32'hC0A8_0001, 1'b1, 32'd1000);
    send_event(rl_pkg::OP_CHECK, 32'hC0A8_0001, 1'b1, 32'd1001);

    run_phase(8'd3, 32'd5000, 31'd8000, 700, 12, 1'b0, 200, $urandom);
    run_phase(8'd1, 32'd0, 31'd1, 3, 10, 1'b0, 200, $urandom);
    run_phase(8'd255, 32'hFFFF_FFFF, 31'd1, 2, 1, 1'b1, 320, $urandom);
    run_phase(8'd0, 32'd1000, 31'h7FFF_FFFF, 300, 12, 1'b0, 200, $urandom);
    run_phase(8'($urandom_range(2, 8)), 32'($urandom_range(100, 20_000)),
              31'($urandom_range(100, 40_000)), $urandom_range(10, 3000), 12, 1'b0, 200,
              $urandom);
    run_phase(8'($urandom_range(2, 8)), 32'($urandom_range(100, 20_000)),
              31'($urandom_range(100, 40_000)), $urandom_range(10, 3000), 8, 1'b0, 200,
              $urandom);
    // back-to-back beats both ways, crossing the clock wrap
    no_idle = 1'b1;
    run_phase(rl_pkg::MAX_FAILURES_RST, rl_pkg::WINDOW_LEN_RST, rl_pkg::BLOCK_LEN_RST,
              9000, 12, 1'b0, 200, 32'hFFF0_0000);
    settle();
    no_idle = 1'b0;

    if (lockout_sb.mismatches == 0 && lockout_sb.pending_verdicts.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
